// ===== sv/assert_macros.svh =====
// Assertion macros used by the election node back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BLN_ASSERT(lbl, c, r, p, m) \
  lbl: assert property (@(posedge c) disable iff (r) (p)) else $error(m);

// Condition must never be true outside reset.
`define BLN_NEVER(lbl, c, r, p, m) \
  `BLN_ASSERT(lbl, c, r, !(p), m)

`endif

// ===== sv/bln_pkg.sv =====
// Shared types, codes and helpers for the bully election node.
package bln_pkg;

  localparam int MAX_NODES = 16;
  localparam int ID_W      = $clog2(MAX_NODES);
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 8;
  localparam int SND_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [1:0] FUNC_ELECTION = 2'd0;
  localparam logic [1:0] FUNC_ALIVE    = 2'd1;
  localparam logic [1:0] FUNC_VICTORY  = 2'd2;
  localparam logic [1:0] FUNC_TICK     = 2'd3;

  localparam logic [1:0] KIND_ELECTION = 2'd0;
  localparam logic [1:0] KIND_ALIVE    = 2'd1;
  localparam logic [1:0] KIND_VICTORY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  typedef struct packed {
    logic [MAX_NODES-1:0] mask;
    logic [1:0]           kind;
    logic                 alive;
    logic [ID_W-1:0]      alive_dest;
    logic [ID_W-1:0]      coord;
    logic                 coord_known;
  } job_t;

  function automatic logic [ID_W-1:0] lowest_index(input logic [MAX_NODES-1:0] m);
    logic [ID_W-1:0] idx;
    idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (m[i]) idx = ID_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== sv/bln_front.sv =====
// Front end: takes input beats, updates election state, builds message jobs.
module bln_front
  import bln_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic [1:0]           in_func,
  input  logic [SND_W-1:0]     in_sender,
  input  logic [TIME_W-1:0]    in_time,
  input  logic                 q_ready,
  output logic                 in_ready,
  output logic                 q_push,
  output job_t                 q_job
);

  logic [ID_W-1:0]      node_id;
  logic [MAX_NODES-1:0] neighbor_mask;
  logic [TMO_W-1:0]     election_timeout;

  logic              running, running_next;
  logic              alive_seen, alive_seen_next;
  logic [TIME_W-1:0] t_start, t_start_next;
  logic              start_valid, start_valid_next;
  logic [ID_W-1:0]   coord, coord_next;
  logic              coord_valid, coord_valid_next;

  logic signed [SND_W-1:0] sender_s;
  logic signed [SND_W-1:0] me_s;
  logic [MAX_NODES-1:0]    above;
  logic [TIME_W-1:0]       st_eff;
  logic                    expired;
  logic                    accept;
  job_t                    job;

  assign sender_s = signed'(in_sender);
  assign me_s     = signed'({1'b0, node_id});
  assign accept   = in_valid && in_ready;
  assign in_ready = q_ready;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      above[i] = neighbor_mask[i] && (ID_W'(i) > node_id);
    end
  end

  assign st_eff  = start_valid ? t_start : in_time;
  assign expired = {1'b0, in_time} > ((TIME_W+1)'(st_eff) + (TIME_W+1)'(election_timeout));

  always_comb begin
    running_next     = running;
    alive_seen_next  = alive_seen;
    t_start_next     = t_start;
    start_valid_next = start_valid;
    coord_next       = coord;
    coord_valid_next = coord_valid;
    job.mask         = '0;
    job.kind         = KIND_ELECTION;
    job.alive        = 1'b0;
    job.alive_dest   = in_sender[ID_W-1:0];
    unique case (in_func)
      FUNC_ELECTION: begin
        running_next = 1'b1;
        if (above != '0) begin
          job.mask  = above;
          job.kind  = KIND_ELECTION;
          job.alive = !sender_s[SND_W-1];
        end else begin
          job.mask = neighbor_mask;
          job.kind = KIND_VICTORY;
          if (neighbor_mask != '0) running_next = 1'b0;
        end
      end
      FUNC_ALIVE: begin
        alive_seen_next = 1'b1;
      end
      FUNC_VICTORY: begin
        if (sender_s < me_s) begin
          job.mask   = neighbor_mask;
          job.kind   = KIND_VICTORY;
          coord_next = node_id;
        end else begin
          coord_next = in_sender[ID_W-1:0];
        end
        coord_valid_next = 1'b1;
        start_valid_next = 1'b0;
        alive_seen_next  = 1'b0;
        running_next     = 1'b0;
      end
      FUNC_TICK: begin
        if (running) begin
          if (!start_valid) begin
            t_start_next     = in_time;
            start_valid_next = 1'b1;
          end
          if (expired && !alive_seen) begin
            job.mask         = neighbor_mask;
            job.kind         = KIND_VICTORY;
            running_next     = 1'b0;
            start_valid_next = 1'b0;
            coord_next       = node_id;
            coord_valid_next = 1'b1;
          end else if (expired) begin
            job.mask         = above;
            job.kind         = KIND_ELECTION;
            start_valid_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    job.coord       = coord_next;
    job.coord_known = coord_valid_next;
  end

  assign q_job  = job;
  assign q_push = accept && ((job.mask != '0) || job.alive);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id          <= '0;
      neighbor_mask    <= '0;
      election_timeout <= TMO_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ID:  node_id          <= cfg_data[ID_W-1:0];
        CFG_NEIGHBOR: neighbor_mask    <= cfg_data[MAX_NODES-1:0];
        CFG_TIMEOUT:  election_timeout <= cfg_data[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      alive_seen  <= 1'b0;
      t_start     <= '0;
      start_valid <= 1'b0;
      coord       <= '0;
      coord_valid <= 1'b0;
    end else if (accept) begin
      running     <= running_next;
      alive_seen  <= alive_seen_next;
      t_start     <= t_start_next;
      start_valid <= start_valid_next;
      coord       <= coord_next;
      coord_valid <= coord_valid_next;
    end
  end

endmodule

// ===== sv/bln_fifo.sv =====
// Two-entry job queue between front and back ends.
module bln_fifo
  import bln_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic ready,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign ready   = count != QCNT_W'(QDEPTH);
  assign valid   = count != '0;
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/bln_back.sv =====
// Back end: walks a job's destination set and emits one message beat per cycle while the output accepts beats.
`include "assert_macros.svh"
module bln_back
  import bln_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  job_t            q_job,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] out_dest,
  output logic [1:0]      out_kind,
  output logic [ID_W-1:0] out_coord,
  output logic            out_known,
  output logic            out_last
);

  logic                 busy;
  logic [MAX_NODES-1:0] rem;
  logic [1:0]           kind;
  logic                 alive;
  logic [ID_W-1:0]      alive_dest;
  logic [ID_W-1:0]      coord;
  logic                 coord_known;

  logic                 slot_free;
  logic                 emit;
  logic                 take_alive;
  logic [ID_W-1:0]      low_idx;
  logic [MAX_NODES-1:0] rem_after;
  logic [ID_W-1:0]      dest_sel;
  logic                 last_sel;

  assign slot_free  = !out_valid || out_ready;
  assign emit       = busy && slot_free;
  assign take_alive = rem == '0;
  assign low_idx    = lowest_index(rem);
  assign rem_after  = rem & (rem - 1'b1);
  assign dest_sel   = take_alive ? alive_dest : low_idx;
  assign last_sel   = take_alive || ((rem_after == '0) && !alive);
  assign q_pop      = !busy && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      alive <= 1'b0;
    end else if (q_pop) begin
      busy        <= 1'b1;
      rem         <= q_job.mask;
      kind        <= q_job.kind;
      alive       <= q_job.alive;
      alive_dest  <= q_job.alive_dest;
      coord       <= q_job.coord;
      coord_known <= q_job.coord_known;
    end else if (emit) begin
      if (take_alive) alive <= 1'b0;
      else rem <= rem_after;
      if (last_sel) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      out_dest  <= dest_sel;
      out_kind  <= take_alive ? KIND_ALIVE : kind;
      out_coord <= coord;
      out_known <= coord_known;
      out_last  <= last_sel;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `BLN_NEVER(a_busy_has_work, clk, rst, busy && (rem == '0) && !alive, "busy job with no messages left")
  `BLN_ASSERT(a_last_ends_job, clk, rst, emit && last_sel |=> !busy, "job still busy after last beat")
  `BLN_ASSERT(a_dest_in_set, clk, rst, emit && !take_alive |-> rem[low_idx], "destination not in job set")

endmodule

// ===== sv/bully_leader_election_node_unit.sv =====
// Top level of one bully leader election node.
// Each input beat updates the node's election state at once; a message-producing input
// becomes a job in a two-entry queue, and the back end sends one message beat per cycle
// while m_tready allows, destinations in ascending id order, with an alive reply last. A
// job holds the back end while it is loaded from the queue and while its messages go out,
// and the next job waits until it ends; a job has at most sixteen messages. Inputs that
// send nothing take no back-end time and are taken every cycle while the queue has room.
// The coordinator fields of every beat show the state after the input that caused it.
module bully_leader_election_node_unit
  import bln_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // sender[4:0], time_now[36:5], zero pad
  input  logic [1:0]           s_tuser,   // func[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // dest[3:0], coordinator[7:4], coordinator_known[8]
  output logic [1:0]           m_tuser,   // kind[1:0]
  output logic                 m_tlast
);

  logic            q_push;
  job_t            push_job;
  logic            q_ready;
  logic            q_pop;
  logic            q_valid;
  job_t            pop_job;
  logic [ID_W-1:0] out_dest;
  logic [ID_W-1:0] out_coord;
  logic            out_known;

  bln_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_func   (s_tuser),
    .in_sender (s_tdata[SND_W-1:0]),
    .in_time   (s_tdata[SND_W+TIME_W-1:SND_W]),
    .q_ready   (q_ready),
    .in_ready  (s_tready),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  bln_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  bln_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_dest  (out_dest),
    .out_kind  (m_tuser),
    .out_coord (out_coord),
    .out_known (out_known),
    .out_last  (m_tlast)
  );

  assign m_tdata = {7'b0, out_known, out_coord, out_dest};

endmodule
